// ----- rtl/core/cfsl_pkg.sv -----
// Shared constants and types for the character frequency list block.
`timescale 1ns / 1ps

package cfsl_pkg;

  // Histogram geometry
  localparam int NUM_CODES   = 96;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int MEM_DEPTH   = 2 ** ADDR_W;

  // Port widths
  localparam int CODE_W    = 7;
  localparam int OUT_CNT_W = 16;

  // Character codes
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd127;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Request codes
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  // One bin offered to the minimum search
  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       idx;
    logic [COUNT_WIDTH-1:0] cnt;
  } cand_t;

  // Running result of the minimum search
  typedef struct packed {
    logic                   found;
    logic                   multi;
    logic [IDX_W-1:0]       idx;
    logic [COUNT_WIDTH-1:0] cnt;
  } best_t;

endpackage

// ----- rtl/core/cfsl_min_track.sv -----
// Running minimum over the snapshot bins presented during one scan.
`timescale 1ns / 1ps

module cfsl_min_track import cfsl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  clear,
  input  cand_t cand,
  output best_t best
);

  best_t best_r;

  // Bins arrive from the highest index down, so a strict compare keeps
  // the higher code among equal counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (clear) begin
      best_r.found <= 1'b0;
      best_r.multi <= 1'b0;
    end else if (cand.en) begin
      if (best_r.found) begin
        best_r.multi <= 1'b1;
      end
      if (!best_r.found || (cand.cnt < best_r.cnt)) begin
        best_r.found <= 1'b1;
        best_r.idx   <= cand.idx;
        best_r.cnt   <= cand.cnt;
      end
    end
  end

  assign best = best_r;

endmodule

// ----- rtl/core/char_frequency_sorted_list.sv -----
// Top level: character histogram with a frequency-ordered readout.
`timescale 1ns / 1ps

// Counts printable codes 32..127 of a text line in a histogram held in one
// synchronous RAM of two banks; newline or carriage return swaps the banks,
// so the finished line becomes the snapshot and the other bank becomes the
// fresh live histogram. Per-bin valid bits make a swapped-in bank read as
// zero at once, so there is no clearing pass after reset or at line end.
// A character byte is read, then written back with a saturating increment in
// S_INC while in_ready is low; a line end or an ignored byte is handled in
// S_IDLE. A pull walks every snapshot bin through the single RAM read port,
// one bin per cycle, then holds its result in S_EMIT until the output register
// is free to load it. Results come in ascending count, higher code first on
// ties, with last_entry on the final nonzero bin and list_empty when none is
// left.
module char_frequency_sorted_list import cfsl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [7:0]           in_char_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_W-1:0]    out_code,
  output logic [OUT_CNT_W-1:0] out_count,
  output logic                 out_last_entry,
  output logic                 out_list_empty
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INC,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                       state_r;
  logic                         live_bank_r;
  logic [1:0][NUM_CODES-1:0]    vld_r;
  logic [NUM_CODES-1:0]         taken_r;
  logic [IDX_W-1:0]             scan_idx_r;
  logic                         issue_r;

  logic                         rd_en_r;
  logic                         rd_bank_r;
  logic [IDX_W-1:0]             rd_idx_r;
  logic [COUNT_WIDTH-1:0]       rd_data_r;

  logic                         out_valid_r;
  logic [CODE_W-1:0]            out_code_r;
  logic [OUT_CNT_W-1:0]         out_count_r;
  logic                         out_last_r;
  logic                         out_empty_r;

  logic [COUNT_WIDTH-1:0]       mem [MEM_DEPTH];

  logic                         accept;
  logic                         is_print;
  logic                         is_eol;
  logic                         in_range;
  logic [7:0]                   idx8;
  logic                         rd_en;
  logic                         rd_bank;
  logic [IDX_W-1:0]             rd_idx;
  logic [COUNT_WIDTH-1:0]       rd_cnt;
  logic                         wr_en;
  logic [COUNT_WIDTH-1:0]       wr_data;
  logic                         scan_done;
  logic                         out_free;
  logic                         emit;
  logic                         pull_start;
  logic [8:0]                   code_sum;
  logic [OUT_CNT_W+COUNT_WIDTH-1:0] cnt_ext;
  cand_t                        cand;
  best_t                        best;

  // Input decode
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_print = (in_char_byte >= FIRST_CODE) && (in_char_byte <= LAST_CODE);
  assign is_eol   = (in_char_byte == CHAR_NL) || (in_char_byte == CHAR_CR);
  assign idx8     = in_char_byte - FIRST_CODE;
  assign in_range = ({1'b0, idx8} < 9'(NUM_CODES));
  assign pull_start = accept && (in_req_type == REQ_PULL);

  // RAM read port: live bin on a character, snapshot bin during a scan
  always_comb begin
    rd_en   = 1'b0;
    rd_bank = live_bank_r;
    rd_idx  = idx8[IDX_W-1:0];
    if (accept && (in_req_type == REQ_CHAR) && is_print && in_range) begin
      rd_en = 1'b1;
    end else if ((state_r == S_SCAN) && issue_r) begin
      rd_en   = 1'b1;
      rd_bank = ~live_bank_r;
      rd_idx  = scan_idx_r;
    end
  end

  // A bin never written since its bank was swapped in reads as zero
  assign rd_cnt  = vld_r[rd_bank_r][rd_idx_r] ? rd_data_r : '0;

  // Saturating write back of a live bin
  assign wr_en   = (state_r == S_INC);
  assign wr_data = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

  // Histogram RAM with a registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{rd_bank_r, rd_idx_r}] <= wr_data;
    end
    rd_data_r <= mem[{rd_bank, rd_idx}];
    rd_bank_r <= rd_bank;
    rd_idx_r  <= rd_idx;
  end

  // Candidate bins for the minimum search
  always_comb begin
    cand.en  = (state_r == S_SCAN) && rd_en_r && !taken_r[rd_idx_r] && (rd_cnt != '0);
    cand.idx = rd_idx_r;
    cand.cnt = rd_cnt;
  end

  cfsl_min_track u_min_track (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (pull_start),
    .cand  (cand),
    .best  (best)
  );

  assign scan_done = (state_r == S_SCAN) && rd_en_r && (rd_idx_r == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (state_r == S_EMIT) && out_free;
  assign code_sum  = 9'(FIRST_CODE) + 9'(best.idx);
  assign cnt_ext   = {{OUT_CNT_W{1'b0}}, best.cnt};

  // Control, valid bits, taken marks and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_bank_r <= 1'b0;
      vld_r       <= '0;
      taken_r     <= '0;
      scan_idx_r  <= '0;
      issue_r     <= 1'b0;
      rd_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_en_r <= rd_en;
      // output register: loaded on emit, emptied by a result transfer
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_req_type == REQ_PULL) begin
              scan_idx_r <= IDX_W'(NUM_CODES - 1);
              issue_r    <= 1'b1;
              state_r    <= S_SCAN;
            end else if (is_print && in_range) begin
              state_r <= S_INC;
            end else if (is_eol) begin
              // swap banks: old live becomes snapshot, old snapshot reads zero
              live_bank_r         <= ~live_bank_r;
              vld_r[~live_bank_r] <= '0;
              taken_r             <= '0;
            end
          end
        end
        S_INC: begin
          vld_r[rd_bank_r][rd_idx_r] <= 1'b1;
          state_r                    <= S_IDLE;
        end
        S_SCAN: begin
          if (issue_r) begin
            if (scan_idx_r == '0) begin
              issue_r <= 1'b0;
            end else begin
              scan_idx_r <= scan_idx_r - 1'b1;
            end
          end
          if (scan_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (best.found) begin
              out_code_r         <= code_sum[CODE_W-1:0];
              out_count_r        <= cnt_ext[OUT_CNT_W-1:0];
              out_last_r         <= !best.multi;
              out_empty_r        <= 1'b0;
              taken_r[best.idx]  <= 1'b1;
            end else begin
              out_code_r  <= '0;
              out_count_r <= '0;
              out_last_r  <= 1'b0;
              out_empty_r <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code       = out_code_r;
  assign out_count      = out_count_r;
  assign out_last_entry = out_last_r;
  assign out_list_empty = out_empty_r;

endmodule

// ----- verif/cfsl_list_checker.sv -----
// Checker for the character frequency list: predicts pull results and compares them.
`timescale 1ns / 1ps

module cfsl_list_checker import cfsl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [7:0]           in_char_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [CODE_W-1:0]    out_code,
  input  logic [OUT_CNT_W-1:0] out_count,
  input  logic                 out_last_entry,
  input  logic                 out_list_empty,
  output int                   fail_count,
  output int                   due_count
);

  // One entry of the frequency-ordered readout
  typedef struct {
    logic [CODE_W-1:0]    code;
    logic [OUT_CNT_W-1:0] count;
    logic                 last;
    logic                 empty;
  } list_entry_t;

  // Mirror of the histogram banks
  logic [COUNT_WIDTH-1:0] live_hist [NUM_CODES];
  logic [COUNT_WIDTH-1:0] line_hist [NUM_CODES];
  logic                   taken     [NUM_CODES];

  list_entry_t entries_due [$];
  int          errors;

  // Lowest untaken nonzero bin; the scan runs from the top so ties favour the higher code
  function automatic int next_in_order();
    int                     pick;
    logic [COUNT_WIDTH-1:0] low;
    pick = -1;
    low  = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (!taken[i] && line_hist[i] != '0 && (pick < 0 || line_hist[i] < low)) begin
        pick = i;
        low  = line_hist[i];
      end
    end
    return pick;
  endfunction

  // Saturating count of printable bytes; line end moves the histogram to the readout bank
  task automatic count_byte(input logic [7:0] b);
    int idx;
    idx = int'(b) - int'(FIRST_CODE);
    if (b >= FIRST_CODE && b <= LAST_CODE) begin
      if (idx < NUM_CODES && live_hist[idx] != CNT_MAX) live_hist[idx] = live_hist[idx] + 1'b1;
    end else if (b == CHAR_NL || b == CHAR_CR) begin
      line_hist = live_hist;
      foreach (live_hist[i]) begin
        live_hist[i] = '0;
        taken[i]     = 1'b0;
      end
    end
  endtask

  // Works out the entry a pull returns and marks it taken
  task automatic predict_pull();
    list_entry_t e;
    int          pick;
    pick = next_in_order();
    if (pick < 0) begin
      e = '{code: '0, count: '0, last: 1'b0, empty: 1'b1};
    end else begin
      taken[pick] = 1'b1;
      e.code  = CODE_W'(pick + int'(FIRST_CODE));
      e.count = OUT_CNT_W'(line_hist[pick]);
      e.last  = (next_in_order() < 0);
      e.empty = 1'b0;
    end
    entries_due.push_back(e);
  endtask

  task automatic flag_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    list_entry_t e;
    if (!rst_n) begin
      foreach (live_hist[i]) begin
        live_hist[i] = '0;
        line_hist[i] = '0;
        taken[i]     = 1'b0;
      end
      entries_due.delete();
      errors = 0;
    end else begin
      // Result transfer: compare with the oldest outstanding entry
      if (out_valid && out_ready) begin
        if (entries_due.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, actual code %0d count %0d",
                   $time, out_code, out_count);
          errors++;
        end else begin
          e = entries_due.pop_front();
          flag_field("code", longint'(e.code), longint'(out_code));
          flag_field("count", longint'(e.count), longint'(out_count));
          flag_field("last_entry", longint'(e.last), longint'(out_last_entry));
          flag_field("list_empty", longint'(e.empty), longint'(out_list_empty));
        end
      end
      // Input transfer: update the mirror
      if (in_valid && in_ready) begin
        if (in_req_type == REQ_PULL) predict_pull();
        else count_byte(in_char_byte);
      end
    end
    fail_count <= errors;
    due_count  <= entries_due.size();
  end

endmodule

// ----- verif/tb_char_frequency_sorted_list.sv -----
// Testbench top for the character frequency list: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_char_frequency_sorted_list;
  import cfsl_pkg::*;

  localparam int ITEMS       = 800;
  localparam int HOLD_CYCLES = 1500;
  localparam int IDLE_LIMIT  = 20000;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_req_type    = REQ_CHAR;
  logic [7:0]           in_char_byte   = 8'h00;
  logic                 out_ready      = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [CODE_W-1:0]    out_code;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_last_entry;
  logic                 out_list_empty;

  int fail_count;
  int due_count;
  int useful;
  int idle_cycles;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  char_frequency_sorted_list i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code       (out_code),
    .out_count      (out_count),
    .out_last_entry (out_last_entry),
    .out_list_empty (out_list_empty)
  );

  cfsl_list_checker i_list_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code       (out_code),
    .out_count      (out_count),
    .out_last_entry (out_last_entry),
    .out_list_empty (out_list_empty),
    .fail_count     (fail_count),
    .due_count      (due_count)
  );

  // Mostly short gaps, now and then a long one; none during calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Offers one item and returns at the edge of its transfer
  task automatic send_item(input logic req, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_PULL || (b >= FIRST_CODE && b <= LAST_CODE) || b == CHAR_NL || b == CHAR_CR)
      useful++;
  endtask

  // Pull requests; the byte field is don't-care, so it carries noise
  task automatic pull_entries(input int n);
    logic [7:0] junk;
    for (int k = 0; k < n; k++) begin
      junk = 8'($urandom_range(0, 255));
      send_item(REQ_PULL, junk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // Receiver: random ready pacing, plus one long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_char_frequency_sorted_list NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0]   b;
    logic [255:0] seen;
    string        text;
    int           distinct;
    int           len;
    int           r;
    int           n_pulls;
    logic         req;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pull straight after reset finds nothing
    send_item(REQ_PULL, 8'h00);
    // Lowest and highest printable codes, a tie, and bytes that must be ignored
    send_item(REQ_CHAR, FIRST_CODE);
    send_item(REQ_CHAR, LAST_CODE);
    send_item(REQ_CHAR, LAST_CODE);
    send_item(REQ_CHAR, 8'h41);
    send_item(REQ_CHAR, 8'h1f);
    send_item(REQ_CHAR, 8'h80);
    send_item(REQ_CHAR, 8'hff);
    send_item(REQ_CHAR, 8'h00);
    send_item(REQ_CHAR, CHAR_NL);
    // Three entries then one pull past the end
    pull_entries(4);
    // Empty line closed by carriage return
    send_item(REQ_CHAR, CHAR_CR);
    pull_entries(2);

    // Back-pressure: receiver holds off while pulls keep coming, then the sender drains
    text = "hold the queue back";
    for (int k = 0; k < text.len(); k++) send_item(REQ_CHAR, text[k]);
    send_item(REQ_CHAR, CHAR_NL);
    hold_req = 1'b1;
    pull_entries(16);
    wait_drained();

    // Random lines: mostly well-formed with readouts, some noise and broken lines
    useful = 0;
    while (useful < ITEMS) begin
      calm = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 12) begin
        req = 1'($urandom_range(0, 1));
        b   = 8'($urandom_range(0, 255));
        send_item(req, b);
      end else begin
        seen     = '0;
        distinct = 0;
        len      = $urandom_range(0, 24);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          // narrow lower-case set gives plenty of equal counts
          if (r < 55) b = 8'($urandom_range(97, 101));
          else if (r < 90) b = 8'($urandom_range(FIRST_CODE, LAST_CODE));
          else b = 8'($urandom_range(0, 255));
          if (b == CHAR_NL || b == CHAR_CR) begin
            seen     = '0;
            distinct = 0;
          end else if (b >= FIRST_CODE && b <= LAST_CODE && !seen[b]) begin
            seen[b] = 1'b1;
            distinct++;
          end
          send_item(REQ_CHAR, b);
        end
        send_item(REQ_CHAR, $urandom_range(0, 1) ? CHAR_NL : CHAR_CR);
        n_pulls = ($urandom_range(0, 3) != 0) ? distinct + 1 : $urandom_range(0, distinct + 2);
        pull_entries(n_pulls);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (4 * NUM_CODES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_char_frequency_sorted_list OK");
    end else begin
      $display("tb_char_frequency_sorted_list NOT OK");
    end
    $finish;
  end

endmodule
